// ===== hw/rtl/mlst_pkg.sv =====
package mlst_pkg;

    localparam int OPERAND_BITS_DEF = 32;
    localparam int INDEX_BITS_DEF   = 64;
    localparam int MOD_BITS         = 31;

    typedef struct packed {
        logic [INDEX_BITS_DEF-1:0]   term_index;
        logic [OPERAND_BITS_DEF-1:0] p_value;
        logic [OPERAND_BITS_DEF-1:0] q_value;
        logic [MOD_BITS-1:0]         modulus;
    } t_in_item;

    typedef struct packed {
        logic [MOD_BITS-1:0] u_term;
        logic [MOD_BITS-1:0] v_term;
    } t_out_item;

    // request to the shared reduction unit
    typedef struct packed {
        logic                  start;
        logic [2*MOD_BITS-1:0] dividend;
    } t_red_req;

    typedef struct packed {
        logic                done;
        logic [MOD_BITS-1:0] rem;
    } t_red_rsp;

endpackage

// ===== hw/rtl/mlst_reducer.sv =====
// Bit-serial restoring remainder: one dividend bit per cycle.
module mlst_reducer
    import mlst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_red_req            i_req,
    input  logic [MOD_BITS-1:0] i_modulus,
    output t_red_rsp            o_rsp
);

    localparam int DW = 2 * MOD_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]     r_dvd;
    logic [MOD_BITS:0] r_rem;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [MOD_BITS+1:0] w_sh;
    logic [MOD_BITS+1:0] w_sub;

    assign w_sh  = {r_rem, r_dvd[DW-1]};
    assign w_sub = w_sh - {2'b00, i_modulus};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_dvd  <= i_req.dividend;
                r_rem  <= '0;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_dvd <= {r_dvd[DW-2:0], 1'b0};
                r_rem <= w_sub[MOD_BITS+1] ? w_sh[MOD_BITS:0] : w_sub[MOD_BITS:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[MOD_BITS-1:0];

endmodule

// ===== hw/rtl/mlst_sequencer.sv =====
// Square-and-multiply control; every product and residue goes through
// the one reducer.
module mlst_sequencer
    import mlst_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF,
    parameter int INDEX_BITS   = INDEX_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [INDEX_BITS-1:0]   i_n,
    input  logic [OPERAND_BITS-1:0] i_p,
    input  logic [OPERAND_BITS-1:0] i_q,
    input  logic [MOD_BITS-1:0]     i_m,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [MOD_BITS-1:0]     o_u,
    output logic [MOD_BITS-1:0]     o_v
);

    localparam int MW = MOD_BITS;
    localparam int DW = 2 * MW;

    typedef enum logic [4:0] {
        S_IDLE, S_PR, S_PNEG, S_QR, S_QNEG, S_SETUP,
        S_BIT, S_MUL0, S_MUL1, S_ADD, S_STORE, S_DOV0, S_DOV1, S_DOV2, S_DONE
    } t_state;

    t_state r_state;
    logic [MW-1:0]         r_m, r_pr, r_qn, r_two, r_one;
    logic [INDEX_BITS-1:0] r_e, r_n;
    logic [OPERAND_BITS-1:0] r_p, r_q;
    logic [MW-1:0] r_a [4];
    logic [MW-1:0] r_b [4];
    logic [MW-1:0] r_t [4];
    logic          r_sq;
    logic [1:0]    r_ij;
    logic          r_half;
    logic [MW-1:0] r_s0;
    logic          r_done;
    logic [MW-1:0] r_u, r_v;

    t_red_req r_req;
    t_red_rsp w_rsp;
    logic [DW-1:0] r_prod;

    mlst_reducer u_red (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req),
        .i_modulus(r_m), .o_rsp(w_rsp)
    );

    logic [MW-1:0] w_x, w_y;
    logic [1:0]    w_xi, w_yi;
    always_comb begin
        w_xi = {r_ij[1], r_half};
        w_yi = {r_half, r_ij[0]};
        w_x  = r_sq ? r_b[w_xi] : r_a[w_xi];
        w_y  = r_b[w_yi];
    end

    logic [OPERAND_BITS-1:0] w_pmag, w_qmag;
    assign w_pmag = i_p[OPERAND_BITS-1] ? (~i_p + 1'b1) : i_p;
    assign w_qmag = r_q[OPERAND_BITS-1] ? (~r_q + 1'b1) : r_q;

    logic [MW:0] w_sum;
    assign w_sum = {1'b0, r_s0} + {1'b0, w_rsp.rem};
    logic [MW:0] w_sumr;
    assign w_sumr = (w_sum >= {1'b0, r_m}) ? w_sum - {1'b0, r_m} : w_sum;

    function automatic logic [MW-1:0] negm(logic [MW-1:0] r, logic [MW-1:0] m);
        return (r == '0) ? '0 : m - r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_m <= i_m; r_n <= i_n; r_q <= i_q; r_p <= i_p;
                    if (i_m == '0) begin
                        r_u <= '0; r_v <= '0; r_state <= S_DONE;
                    end else begin
                        r_req.dividend <= DW'(w_pmag);
                        r_req.start <= 1'b1;
                        r_state <= S_PR;
                    end
                end
                S_PR: if (w_rsp.done) begin
                    r_pr <= r_p[OPERAND_BITS-1] ? negm(w_rsp.rem, r_m) : w_rsp.rem;
                    r_req.dividend <= DW'(w_qmag);
                    r_req.start <= 1'b1;
                    r_state <= S_QR;
                end
                S_QR: if (w_rsp.done) begin
                    r_qn <= r_q[OPERAND_BITS-1] ? w_rsp.rem : negm(w_rsp.rem, r_m);
                    r_one <= (r_m == MW'(1)) ? '0 : MW'(1);
                    r_two <= (r_m == MW'(1)) ? '0 : (r_m == MW'(2)) ? '0 : MW'(2);
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    if (r_n == '0) begin
                        r_u <= '0; r_v <= r_two; r_state <= S_DONE;
                    end else if (r_n == INDEX_BITS'(1)) begin
                        r_u <= r_one; r_v <= r_pr; r_state <= S_DONE;
                    end else begin
                        r_b[0] <= r_pr; r_b[1] <= r_qn; r_b[2] <= r_one; r_b[3] <= '0;
                        r_a[0] <= r_one; r_a[1] <= '0; r_a[2] <= '0; r_a[3] <= r_one;
                        r_e <= r_n - INDEX_BITS'(1);
                        r_state <= S_BIT;
                    end
                end
                S_BIT: begin
                    if (r_e == '0) begin
                        r_half <= 1'b0;
                        r_state <= S_DOV0;
                    end else begin
                        r_sq <= ~r_e[0];
                        r_ij <= '0; r_half <= 1'b0;
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_prod <= DW'(w_x) * DW'(w_y);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_req.dividend <= r_prod; r_req.start <= 1'b1;
                    r_state <= S_ADD;
                end
                S_ADD: if (w_rsp.done) begin
                    if (!r_half) begin
                        r_s0 <= w_rsp.rem; r_half <= 1'b1; r_state <= S_MUL0;
                    end else begin
                        r_t[r_ij] <= w_sumr[MW-1:0];
                        r_half <= 1'b0;
                        if (r_ij == 2'd3) r_state <= S_STORE;
                        else begin r_ij <= r_ij + 2'd1; r_state <= S_MUL0; end
                    end
                end
                S_STORE: begin
                    // after a multiply the low bit is cleared, and the
                    // squaring that follows does the shift
                    if (!r_sq) begin
                        r_a <= r_t;
                        if (r_e == INDEX_BITS'(1)) begin
                            r_e <= '0; r_state <= S_BIT;
                        end else begin
                            r_e <= {r_e[INDEX_BITS-1:1], 1'b0};
                            r_sq <= 1'b1; r_ij <= '0; r_state <= S_MUL0;
                        end
                    end else begin
                        r_b <= r_t;
                        r_e <= r_e >> 1;
                        r_state <= S_BIT;
                    end
                end
                S_DOV0: begin
                    r_prod <= DW'(r_a[0]) * DW'(r_pr);
                    r_state <= S_DOV1;
                end
                S_DOV1: begin
                    r_req.dividend <= r_prod; r_req.start <= 1'b1;
                    r_state <= S_DOV2;
                end
                S_DOV2: if (w_rsp.done) begin
                    if (!r_half) begin
                        r_s0 <= w_rsp.rem; r_half <= 1'b1;
                        r_prod <= DW'(r_a[1]) * DW'(r_two);
                        r_state <= S_DOV1;
                    end else begin
                        r_u <= r_a[0]; r_v <= w_sumr[MW-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_done <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_u = r_u;
    assign o_v = r_v;

endmodule

// ===== hw/rtl/modular_lucas_sequence_term.sv =====
// Modular Lucas sequence term: U_n(P,Q) mod m and V_n(P,Q) mod m.
// Input channel: i_in_valid / o_in_stall carry one item (n, P, Q, m).
// Output channel: o_out_valid / i_out_stall carry one result item (U, V).
// An item is taken when valid is high and stall is low.
// One item is worked on at a time; o_in_stall stays high from acceptance
// until the result has left the sequencer.
// Each modular product is one 31x31 multiply, an issue state, then a
// bit-serial 62-bit remainder; a 2x2 matrix product is eight of them.
// n-1 costs one squaring per bit below its top bit and one multiply per
// set bit. For n = 0 and n = 1 only the residues of P and Q are worked
// out; m = 0 skips even those.
// The output register holds its item while the receiver stalls; one more
// finished result waits behind it, and no new item is taken while that
// second slot is full or about to fill.
// Reset (synchronous, active low) empties both output slots and returns
// the sequencer to idle; no state survives between items.
module modular_lucas_sequence_term
    import mlst_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF,
    parameter int INDEX_BITS   = INDEX_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic w_busy, w_done;
    logic [MOD_BITS-1:0] w_u, w_v;
    logic w_accept;
    logic w_free;
    logic r_pend;  // result finished but output register still full
    logic [MOD_BITS-1:0] r_pu, r_pv;
    logic r_ovalid;
    t_out_item r_oitem;

    assign w_free     = ~r_ovalid | ~i_out_stall;
    // hold off while busy, while a result is parked, or is about to be
    assign o_in_stall = w_busy | r_pend | (w_done & ~w_free);
    assign w_accept   = i_in_valid & ~o_in_stall;

    mlst_sequencer #(
        .OPERAND_BITS(OPERAND_BITS), .INDEX_BITS(INDEX_BITS)
    ) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_accept),
        .i_n(INDEX_BITS'(i_in_item.term_index)),
        .i_p(OPERAND_BITS'(i_in_item.p_value)),
        .i_q(OPERAND_BITS'(i_in_item.q_value)),
        .i_m(i_in_item.modulus),
        .o_busy(w_busy), .o_done(w_done), .o_u(w_u), .o_v(w_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            if (w_done) begin
                if (w_free) begin
                    r_ovalid <= 1'b1;
                    r_oitem.u_term <= w_u; r_oitem.v_term <= w_v;
                end else begin
                    r_pend <= 1'b1; r_pu <= w_u; r_pv <= w_v;
                end
            end else if (r_pend && w_free) begin
                r_ovalid <= 1'b1; r_pend <= 1'b0;
                r_oitem.u_term <= r_pu; r_oitem.v_term <= r_pv;
            end else if (w_free) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

endmodule

// ===== verif/tb_modular_lucas_sequence_term.sv =====
module tb_modular_lucas_sequence_term;
    import mlst_pkg::*;

    localparam int CLK_HIGH    = 6;
    localparam int CLK_LOW     = 6;
    localparam int RESET_CYCLES = 11;
    // the worst case for one 64-bit index is 126 matrix products; the idle
    // limit is set above the time they take
    localparam int IDLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 140;
    localparam int HOLD_CYCLES  = 3000;

    typedef enum int {
        PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD
    } t_phase;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    modular_lucas_sequence_term i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        clk = 1'b1;
        #CLK_HIGH;
        clk = 1'b0;
        #CLK_LOW;
    end

    t_in_item  pending_items[$];
    t_out_item lucas_terms_due[$];
    t_phase    phase;
    int        fail_count;
    int        idle_count;
    int        hold_count;
    bit        hold_done;

    // residue of a signed operand modulo m
    function automatic longint unsigned signed_mod(logic [31:0] raw,
                                                   longint unsigned m);
        longint unsigned mag;
        if (raw[31]) begin
            mag = {32'd0, ~raw} + 64'd1;
            return (m - (mag % m)) % m;
        end
        return {32'd0, raw} % m;
    endfunction

    function automatic t_out_item lucas_term(t_in_item it);
        t_out_item       r;
        longint unsigned m, pr, qn, two, e;
        longint unsigned b00, b01, b10, b11, a00, a01, a10, a11;
        longint unsigned t00, t01, t10, t11;
        m = {33'd0, it.modulus};
        r = '0;
        if (m == 0) return r;
        pr  = signed_mod(it.p_value, m);
        qn  = (m - signed_mod(it.q_value, m)) % m;
        two = 2 % m;
        if (it.term_index == 0) begin
            r.v_term = two[30:0];
            return r;
        end
        if (it.term_index == 1) begin
            r.u_term = 31'(1 % m);
            r.v_term = pr[30:0];
            return r;
        end
        b00 = pr; b01 = qn; b10 = 1 % m; b11 = 0;
        a00 = 1 % m; a01 = 0; a10 = 0; a11 = 1 % m;
        e = it.term_index - 1;
        while (e != 0) begin
            if (e[0]) begin
                t00 = ((a00 * b00) % m + (a01 * b10) % m) % m;
                t01 = ((a00 * b01) % m + (a01 * b11) % m) % m;
                t10 = ((a10 * b00) % m + (a11 * b10) % m) % m;
                t11 = ((a10 * b01) % m + (a11 * b11) % m) % m;
                a00 = t00; a01 = t01; a10 = t10; a11 = t11;
            end
            e = e >> 1;
            if (e != 0) begin
                t00 = ((b00 * b00) % m + (b01 * b10) % m) % m;
                t01 = ((b00 * b01) % m + (b01 * b11) % m) % m;
                t10 = ((b10 * b00) % m + (b11 * b10) % m) % m;
                t11 = ((b10 * b01) % m + (b11 * b11) % m) % m;
                b00 = t00; b01 = t01; b10 = t10; b11 = t11;
            end
        end
        r.u_term = 31'(a00 % m);
        r.v_term = 31'(((a00 * pr) % m + (a01 * two) % m) % m);
        return r;
    endfunction

    function automatic t_in_item make_item(logic [63:0] n, logic [31:0] p,
                                           logic [31:0] q, logic [30:0] m);
        t_in_item it;
        it.term_index = n;
        it.p_value    = p;
        it.q_value    = q;
        it.modulus    = m;
        return it;
    endfunction

    // random item: mostly small indices so runs stay short, a few full width
    function automatic t_in_item rand_item();
        logic [63:0] n;
        logic [30:0] m;
        case ($urandom_range(9))
            0: n = {$urandom, $urandom};
            1, 2: n = 64'($urandom_range(3));
            default: n = 64'($urandom_range(4095));
        endcase
        case ($urandom_range(5))
            0: m = 31'($urandom_range(3));
            1: m = 31'h7fff_ffff - 31'($urandom_range(3));
            default: m = 31'($urandom);
        endcase
        return make_item(n, $urandom, $urandom, m);
    endfunction

    // driver: offers the head of the queue; idles by phase
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) void'(pending_items.pop_front());
            if (in_valid && in_stall) begin
                // payload is held while stalled
            end else if (pending_items.size() == 0 ||
                         (in_valid && !in_stall && pending_items.size() == 0)) begin
                in_valid <= 1'b0;
            end else if ((phase == PH_SEND_IDLE && $urandom_range(99) < 87) ||
                         (phase == PH_BOTH && $urandom_range(99) < 38)) begin
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                in_item  <= pending_items[0];
            end
        end
    end

    // receiver stall, plus one long hold-off to back the block up
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            hold_count <= 0;
            hold_done  <= 1'b0;
        end else if (phase == PH_HOLD && !hold_done) begin
            out_stall  <= (hold_count != HOLD_CYCLES);
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
        end else if (phase == PH_RECV_STALL) begin
            out_stall <= ($urandom_range(99) < 87);
        end else if (phase == PH_BOTH) begin
            out_stall <= ($urandom_range(99) < 38);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // monitor: predict on input acceptance, compare on output acceptance
    always @(posedge clk) begin
        t_out_item due;
        if (rst_n) begin
            if (in_valid && !in_stall) lucas_terms_due.push_back(lucas_term(in_item));
            if (out_valid && !out_stall) begin
                if (lucas_terms_due.size() == 0) begin
                    $display("%0t: unexpected item u=%0d v=%0d", $time,
                             out_item.u_term, out_item.v_term);
                    fail_count = fail_count + 1;
                end else begin
                    due = lucas_terms_due.pop_front();
                    if (due.u_term !== out_item.u_term) begin
                        $display("%0t: u_term expected %0d actual %0d", $time,
                                 due.u_term, out_item.u_term);
                        fail_count = fail_count + 1;
                    end
                    if (due.v_term !== out_item.v_term) begin
                        $display("%0t: v_term expected %0d actual %0d", $time,
                                 due.v_term, out_item.v_term);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no acceptance on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("FAIL modular_lucas_sequence_term");
            $finish;
        end
    end

    // queues are checked mid-cycle, clear of the clocked processes
    task automatic run_phase(t_phase ph, int count);
        phase = ph;
        for (int k = 0; k < count; k++) pending_items.push_back(rand_item());
        while (pending_items.size() != 0 || lucas_terms_due.size() != 0)
            @(negedge clk);
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        out_stall  = 1'b0;
        phase      = PH_FREE;
        fail_count = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: index zero and one, m = 1, zero modulus, sign extremes
        pending_items.push_back(make_item(64'd0, 32'd5, 32'd3, 31'd7));
        pending_items.push_back(make_item(64'd1, 32'hffff_fffd, 32'd3, 31'd7));
        pending_items.push_back(make_item(64'd1, 32'd9, 32'd3, 31'd1));
        pending_items.push_back(make_item(64'd0, 32'd9, 32'd3, 31'd1));
        pending_items.push_back(make_item(64'd10, 32'd9, 32'd3, 31'd0));
        pending_items.push_back(make_item(64'd0, 32'd9, 32'd3, 31'd0));
        pending_items.push_back(make_item(64'd2, 32'd1, 32'hffff_ffff, 31'd1000));
        pending_items.push_back(make_item(64'd10, 32'd1, 32'hffff_ffff, 31'h7fff_ffff));
        pending_items.push_back(make_item(64'd20, 32'h8000_0000, 32'h7fff_ffff,
                                          31'h7fff_ffff));
        pending_items.push_back(make_item(64'd33, 32'h7fff_ffff, 32'h8000_0000,
                                          31'h7fff_fffe));
        pending_items.push_back(make_item(64'hffff_ffff_ffff_ffff, 32'hffff_ffff,
                                          32'hffff_ffff, 31'h7fff_ffff));
        pending_items.push_back(make_item(64'h8000_0000_0000_0000, 32'd3, 32'd2,
                                          31'd1_000_003));
        pending_items.push_back(make_item(64'd3, 32'd0, 32'd0, 31'd2));
        pending_items.push_back(make_item(64'd100, 32'd2, 32'd1, 31'd12345));
        run_phase(PH_FREE, 0);

        run_phase(PH_FREE, 35);
        run_phase(PH_SEND_IDLE, 30);
        run_phase(PH_RECV_STALL, 30);
        run_phase(PH_BOTH, 30);

        // short items, so the output register and the waiting slot both fill inside the hold-off
        for (int k = 0; k < 15; k++)
            pending_items.push_back(make_item(64'($urandom_range(3)), $urandom,
                                              $urandom, 31'($urandom)));
        run_phase(PH_HOLD, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && lucas_terms_due.size() == 0)
            $display("PASS modular_lucas_sequence_term");
        else
            $display("FAIL modular_lucas_sequence_term");
        $finish;
    end

endmodule
